@@ src/fat_boot_sector_geometry_check_core_assert.svh @@
// ----------------------------------------------------------------------------
// FAT boot sector geometry check - assertion macros
// Property shorthands used by the core. They sample on clk and are disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_BOOT_SECTOR_GEOMETRY_CHECK_CORE_ASSERT_SVH
`define FAT_BOOT_SECTOR_GEOMETRY_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define FBGC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fbgc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbgc_pkg
// Types and constants shared by the FAT boot sector geometry check pipeline.
// ----------------------------------------------------------------------------
package fbgc_pkg;

	// cluster count limits per FAT type
	localparam logic [31:0] MAX_FAT12 = 32'h0000_0FF5;
	localparam logic [31:0] MAX_FAT16 = 32'h0000_FFF5;
	localparam logic [31:0] MAX_FAT32 = 32'h0FFF_FFF5;

	// physical sector size after reset
	localparam logic [12:0] SECTOR_SIZE_RESET = 13'd512;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_FS   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FT_NONE  = 2'd0,
		FT_FAT12 = 2'd1,
		FT_FAT16 = 2'd2,
		FT_FAT32 = 2'd3
	} fat_type_t;

	// decoded boot sector record
	typedef struct packed {
		logic [15:0] bpb_sector_size;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] reserved_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] root_entries;
		logic [15:0] total_sectors_small;
		logic [15:0] fat_size_small;
		logic [31:0] fat_size_large;
		logic [31:0] total_sectors_large;
		logic [31:0] root_cluster;
		logic [31:0] volume_base;
	} bpb_t;

	// after field checks and selection
	typedef struct packed {
		logic        ok;
		logic [3:0]  sshift;
		logic [2:0]  cshift;
		logic [31:0] total;
		logic [31:0] fsz;
		logic [32:0] fat_area;
		logic [11:0] root_sec;
		logic [15:0] rsv;
		logic [31:0] fstart;
		logic [31:0] vbase;
		logic [31:0] rclu;
		logic        roots_nz;
	} dec_t;

	// after system area subtraction
	typedef struct packed {
		logic        ok;
		logic [3:0]  sshift;
		logic [2:0]  cshift;
		logic        underflow;
		logic [31:0] diff;
		logic [31:0] fsz;
		logic [31:0] fstart;
		logic [31:0] dstart;
		logic [31:0] rbase;
		logic [31:0] rclu;
		logic        roots_nz;
	} area_t;

	// after root rule and FAT size requirement
	typedef struct packed {
		logic        ok;
		logic [3:0]  sshift;
		status_t     status;
		fat_type_t   fat_type;
		logic [31:0] count;
		logic [31:0] entries;
		logic [31:0] fsz;
		logic [31:0] fstart;
		logic [31:0] dstart;
		logic [31:0] rstart;
		logic [33:0] need;
	} chk_t;

	// final result
	typedef struct packed {
		status_t     status;
		fat_type_t   fat_type;
		logic [31:0] cluster_count;
		logic [31:0] fat_entries;
		logic [31:0] fat_sectors;
		logic [31:0] fat_start;
		logic [31:0] data_start;
		logic [31:0] root_start;
	} res_t;

endpackage

@@ src/fat_boot_sector_geometry_check_core.sv @@
// ----------------------------------------------------------------------------
// fat_boot_sector_geometry_check_core
// Checks one decoded FAT boot sector per transfer and returns volume layout.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: boot sector fields
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: layout, tuser: status/type
// cfg       in   cfg_valid/cfg_ready           cfg_data: physical sector size
//
// Six register stages; one transfer per cycle in, one per cycle out, while
// m_axis_tready is high. Each stage has its own ready, so a
// stalled output fills empty stages before the input stalls. Reset empties
// the pipeline and sets the sector size to 512. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "fat_boot_sector_geometry_check_core_assert.svh"

module fat_boot_sector_geometry_check_core (
	input  logic         clk,
	input  logic         arst_n,
	// input record
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// bpb_sector_size, sectors_per_cluster, reserved_sectors, fat_copies,
	// root_entries, total_sectors_small, fat_size_small, fat_size_large,
	// total_sectors_large, root_cluster, volume_base
	input  logic [223:0] s_axis_tdata,
	// result
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// cluster_count, fat_entries, fat_sectors, fat_start, data_start, root_start
	output logic [191:0] m_axis_tdata,
	// status, fat_type
	output logic [3:0]   m_axis_tuser,
	// sector size register
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [12:0]  cfg_data
);

	logic [12:0]     sector_size_q;
	fbgc_pkg::bpb_t  bpb;
	fbgc_pkg::dec_t  dec;
	fbgc_pkg::area_t area;
	fbgc_pkg::chk_t  chk;
	fbgc_pkg::res_t  res;
	logic            dec_valid, dec_ready;
	logic            area_valid, area_ready;
	logic            chk_valid, chk_ready;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_size_q <= fbgc_pkg::SECTOR_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sector_size_q <= cfg_data;
		end
	end

	// unpack input fields
	assign bpb.bpb_sector_size     = s_axis_tdata[15:0];
	assign bpb.sectors_per_cluster = s_axis_tdata[23:16];
	assign bpb.reserved_sectors    = s_axis_tdata[39:24];
	assign bpb.fat_copies          = s_axis_tdata[47:40];
	assign bpb.root_entries        = s_axis_tdata[63:48];
	assign bpb.total_sectors_small = s_axis_tdata[79:64];
	assign bpb.fat_size_small      = s_axis_tdata[95:80];
	assign bpb.fat_size_large      = s_axis_tdata[127:96];
	assign bpb.total_sectors_large = s_axis_tdata[159:128];
	assign bpb.root_cluster        = s_axis_tdata[191:160];
	assign bpb.volume_base         = s_axis_tdata[223:192];

	fbgc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_bpb      (bpb),
		.sector_size (sector_size_q),
		.out_valid   (dec_valid),
		.out_ready   (dec_ready),
		.out_dec     (dec)
	);

	fbgc_area u_area (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_dec    (dec),
		.out_valid (area_valid),
		.out_ready (area_ready),
		.out_area  (area)
	);

	fbgc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (area_valid),
		.in_ready  (area_ready),
		.in_area   (area),
		.out_valid (chk_valid),
		.out_ready (chk_ready),
		.out_chk   (chk)
	);

	fbgc_fatchk u_fatchk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chk_valid),
		.in_ready  (chk_ready),
		.in_chk    (chk),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// pack result
	assign m_axis_tdata = {res.root_start, res.data_start, res.fat_start,
	                       res.fat_sectors, res.fat_entries, res.cluster_count};
	assign m_axis_tuser = {res.fat_type, res.status};

	// checks
	`FBGC_ASSERT_NOW(a_ok_has_type, m_axis_tvalid && res.status == fbgc_pkg::ST_OK, res.fat_type != fbgc_pkg::FT_NONE && res.cluster_count != 32'd0, "ok result without FAT type or clusters")
	`FBGC_ASSERT_NOW(a_entries_sum, m_axis_tvalid && res.fat_type != fbgc_pkg::FT_NONE, res.fat_entries == res.cluster_count + 32'd2, "fat_entries is not cluster count plus two")
	`FBGC_ASSERT_NOW(a_no_type_no_root, m_axis_tvalid && res.fat_type == fbgc_pkg::FT_NONE, res.root_start == 32'd0 && res.status != fbgc_pkg::ST_OK, "root start set without FAT type")
	`FBGC_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, sector_size_q == $past(cfg_data), "sector size register missed a write")

endmodule

@@ src/fbgc_decode.sv @@
// ----------------------------------------------------------------------------
// fbgc_decode
// Stage 1: field checks, sector and cluster shifts, 16/32-bit field picks.
// ----------------------------------------------------------------------------
module fbgc_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fbgc_pkg::bpb_t in_bpb,
	input  logic [12:0]    sector_size,
	output logic           out_valid,
	input  logic           out_ready,
	output fbgc_pkg::dec_t out_dec
);

	logic           valid_s1;
	fbgc_pkg::dec_t dec_s1;
	fbgc_pkg::dec_t dec_d;
	logic           ss_ok;
	logic [3:0]     sshift;
	logic [2:0]     eshift;
	logic [15:0]    root_mask;
	logic           spc_ok;
	logic           copies_ok;
	logic [2:0]     cshift;
	logic [31:0]    fsz;

	// checks and field selection
	always_comb begin
		ss_ok  = 1'b1;
		sshift = 4'd9;
		case (sector_size)
			13'd512:  sshift = 4'd9;
			13'd1024: sshift = 4'd10;
			13'd2048: sshift = 4'd11;
			13'd4096: sshift = 4'd12;
			default: begin
				ss_ok  = 1'b0;
				sshift = 4'd9;
			end
		endcase
		// 32-byte directory entries: entries per sector = 2^(sshift-5)
		eshift    = 3'(sshift - 4'd5);
		root_mask = (16'd1 << eshift) - 16'd1;

		spc_ok = (in_bpb.sectors_per_cluster != 8'd0) &&
			((in_bpb.sectors_per_cluster & (in_bpb.sectors_per_cluster - 8'd1)) == 8'd0);
		copies_ok = (in_bpb.fat_copies == 8'd1) || (in_bpb.fat_copies == 8'd2);

		// highest set bit of the cluster size
		cshift = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (in_bpb.sectors_per_cluster[i]) cshift = 3'(i);
		end

		fsz = (in_bpb.fat_size_small != 16'd0) ? {16'd0, in_bpb.fat_size_small}
		                                       : in_bpb.fat_size_large;

		dec_d.ok = ss_ok && (in_bpb.bpb_sector_size == {3'd0, sector_size}) &&
			copies_ok && spc_ok && ((in_bpb.root_entries & root_mask) == 16'd0) &&
			(in_bpb.reserved_sectors != 16'd0);
		dec_d.sshift   = sshift;
		dec_d.cshift   = cshift;
		dec_d.total    = (in_bpb.total_sectors_small != 16'd0) ?
			{16'd0, in_bpb.total_sectors_small} : in_bpb.total_sectors_large;
		dec_d.fsz      = fsz;
		dec_d.fat_area = (in_bpb.fat_copies == 8'd2) ? {fsz, 1'b0} : {1'b0, fsz};
		dec_d.root_sec = 12'(in_bpb.root_entries >> eshift);
		dec_d.rsv      = in_bpb.reserved_sectors;
		dec_d.fstart   = in_bpb.volume_base + {16'd0, in_bpb.reserved_sectors};
		dec_d.vbase    = in_bpb.volume_base;
		dec_d.rclu     = in_bpb.root_cluster;
		dec_d.roots_nz = (in_bpb.root_entries != 16'd0);
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_s1 <= dec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_dec   = dec_s1;

endmodule

@@ src/fbgc_area.sv @@
// ----------------------------------------------------------------------------
// fbgc_area
// Stages 2-3: system area sum, then total minus system area and base sums.
// ----------------------------------------------------------------------------
module fbgc_area (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  fbgc_pkg::dec_t  in_dec,
	output logic            out_valid,
	input  logic            out_ready,
	output fbgc_pkg::area_t out_area
);

	logic            valid_s2;
	logic            valid_s3;
	logic            rdy_s3;
	fbgc_pkg::dec_t  dec_s2;
	logic [33:0]     sys_s2;
	fbgc_pkg::area_t area_s3;
	fbgc_pkg::area_t area_d;
	logic [34:0]     diff;

	// total minus system area, borrow marks underflow
	always_comb begin
		diff = {3'd0, dec_s2.total} - {1'b0, sys_s2};
		area_d.ok        = dec_s2.ok;
		area_d.sshift    = dec_s2.sshift;
		area_d.cshift    = dec_s2.cshift;
		area_d.underflow = diff[34];
		area_d.diff      = diff[31:0];
		area_d.fsz       = dec_s2.fsz;
		area_d.fstart    = dec_s2.fstart;
		area_d.dstart    = dec_s2.vbase + sys_s2[31:0];
		area_d.rbase     = dec_s2.fstart + dec_s2.fat_area[31:0];
		area_d.rclu      = dec_s2.rclu;
		area_d.roots_nz  = dec_s2.roots_nz;
	end

	assign rdy_s3   = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || rdy_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) valid_s2 <= in_valid;
			if (rdy_s3)   valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_s2 <= in_dec;
			sys_s2 <= 34'(in_dec.rsv) + 34'(in_dec.fat_area) + 34'(in_dec.root_sec);
		end
		if (valid_s2 && rdy_s3) begin
			area_s3 <= area_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_area  = area_s3;

endmodule

@@ src/fbgc_classify.sv @@
// ----------------------------------------------------------------------------
// fbgc_classify
// Stages 4-5: cluster count and FAT type, then root rule and FAT size need.
// ----------------------------------------------------------------------------
module fbgc_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  fbgc_pkg::area_t in_area,
	output logic            out_valid,
	input  logic            out_ready,
	output fbgc_pkg::chk_t  out_chk
);

	typedef struct packed {
		logic                ok;
		logic [3:0]          sshift;
		fbgc_pkg::fat_type_t fat_type;
		logic [31:0]         count;
		logic [32:0]         entries;
		logic [31:0]         fsz;
		logic [31:0]         fstart;
		logic [31:0]         dstart;
		logic [31:0]         rbase;
		logic [31:0]         rclu;
		logic                roots_nz;
	} cls_t;

	logic           valid_s4;
	logic           valid_s5;
	logic           rdy_s5;
	cls_t           cls_s4;
	cls_t           cls_d;
	fbgc_pkg::chk_t chk_s5;
	fbgc_pkg::chk_t chk_d;
	logic [31:0]    count;
	logic           root_fail;
	logic [33:0]    three_e;

	// cluster count and type
	always_comb begin
		count = in_area.underflow ? 32'd0 : (in_area.diff >> in_area.cshift);
		cls_d.ok     = in_area.ok;
		cls_d.sshift = in_area.sshift;
		cls_d.count  = count;
		if ((count == 32'd0) || (count > fbgc_pkg::MAX_FAT32)) begin
			cls_d.fat_type = fbgc_pkg::FT_NONE;
		end else if (count <= fbgc_pkg::MAX_FAT12) begin
			cls_d.fat_type = fbgc_pkg::FT_FAT12;
		end else if (count <= fbgc_pkg::MAX_FAT16) begin
			cls_d.fat_type = fbgc_pkg::FT_FAT16;
		end else begin
			cls_d.fat_type = fbgc_pkg::FT_FAT32;
		end
		cls_d.entries  = 33'(count) + 33'd2;
		cls_d.fsz      = in_area.fsz;
		cls_d.fstart   = in_area.fstart;
		cls_d.dstart   = in_area.dstart;
		cls_d.rbase    = in_area.rbase;
		cls_d.rclu     = in_area.rclu;
		cls_d.roots_nz = in_area.roots_nz;
	end

	// root rule, root base and bytes of FAT needed
	always_comb begin
		three_e   = 34'({cls_s4.entries, 1'b0}) + 34'(cls_s4.entries);
		root_fail = 1'b0;
		chk_d.rstart = 32'd0;
		chk_d.need   = 34'(cls_s4.entries);
		case (cls_s4.fat_type)
			fbgc_pkg::FT_FAT32: begin
				root_fail = cls_s4.roots_nz;
				if (!cls_s4.roots_nz) begin
					chk_d.rstart = cls_s4.rclu;
					chk_d.need   = {cls_s4.entries[31:0], 2'b00};
				end
			end
			fbgc_pkg::FT_FAT16: begin
				root_fail = !cls_s4.roots_nz;
				if (cls_s4.roots_nz) begin
					chk_d.rstart = cls_s4.rbase;
					chk_d.need   = 34'({cls_s4.entries, 1'b0});
				end
			end
			fbgc_pkg::FT_FAT12: begin
				root_fail = !cls_s4.roots_nz;
				if (cls_s4.roots_nz) begin
					chk_d.rstart = cls_s4.rbase;
					// 1.5 bytes per entry, odd count rounds up
					chk_d.need   = (three_e >> 1) + 34'(cls_s4.entries[0]);
				end
			end
			default: begin
				root_fail = 1'b0;
			end
		endcase

		if (root_fail) begin
			chk_d.status = fbgc_pkg::ST_NO_FS;
		end else if (cls_s4.fat_type == fbgc_pkg::FT_NONE) begin
			chk_d.status = fbgc_pkg::ST_INVALID;
		end else begin
			chk_d.status = fbgc_pkg::ST_OK;
		end
		chk_d.ok       = cls_s4.ok;
		chk_d.sshift   = cls_s4.sshift;
		chk_d.fat_type = cls_s4.fat_type;
		chk_d.count    = cls_s4.count;
		chk_d.entries  = cls_s4.entries[31:0];
		chk_d.fsz      = cls_s4.fsz;
		chk_d.fstart   = cls_s4.fstart;
		chk_d.dstart   = cls_s4.dstart;
	end

	assign rdy_s5   = !valid_s5 || out_ready;
	assign in_ready = !valid_s4 || rdy_s5;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready) valid_s4 <= in_valid;
			if (rdy_s5)   valid_s5 <= valid_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s4 <= cls_d;
		end
		if (valid_s4 && rdy_s5) begin
			chk_s5 <= chk_d;
		end
	end

	assign out_valid = valid_s5;
	assign out_chk   = chk_s5;

endmodule

@@ src/fbgc_fatchk.sv @@
// ----------------------------------------------------------------------------
// fbgc_fatchk
// Stage 6: round FAT need up to sectors, final status, output register.
// ----------------------------------------------------------------------------
module fbgc_fatchk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fbgc_pkg::chk_t in_chk,
	output logic           out_valid,
	input  logic           out_ready,
	output fbgc_pkg::res_t out_res
);

	logic           valid_s6;
	fbgc_pkg::res_t res_s6;
	fbgc_pkg::res_t res_d;
	logic [33:0]    mask;
	logic [33:0]    need_sec;
	logic           fat_small;

	// ceil(need / sector size) against the FAT size
	always_comb begin
		mask      = (34'd1 << in_chk.sshift) - 34'd1;
		need_sec  = (in_chk.need >> in_chk.sshift) + 34'(|(in_chk.need & mask));
		fat_small = {2'd0, in_chk.fsz} < need_sec;

		if (!in_chk.ok) begin
			res_d               = '0;
			res_d.status        = fbgc_pkg::ST_INVALID;
		end else begin
			res_d.status        = fat_small ? fbgc_pkg::ST_INVALID : in_chk.status;
			res_d.fat_type      = in_chk.fat_type;
			res_d.cluster_count = in_chk.count;
			res_d.fat_entries   = in_chk.entries;
			res_d.fat_sectors   = in_chk.fsz;
			res_d.fat_start     = in_chk.fstart;
			res_d.data_start    = in_chk.dstart;
			res_d.root_start    = in_chk.rstart;
		end
	end

	assign in_ready = !valid_s6 || out_ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (in_ready) begin
			valid_s6 <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s6 <= res_d;
		end
	end

	assign out_valid = valid_s6;
	assign out_res   = res_s6;

endmodule
